// ===== rtl/mas_pkg.sv =====
// ----------------------------------------------------------------------------
// mas_pkg: shared types and codes of the matrix add/sub/multiply unit
// Input kinds, operation modes, register indexes, result range and the
// configuration bundle handed from the register file to the engine.
// ----------------------------------------------------------------------------
package mas_pkg;

    localparam int KIND_W     = 2;
    localparam int IDX_W      = 3;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int DIM_REG_W  = 4;
    localparam int MODE_W     = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MUL    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_OP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS  = 2'd3;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 4'd8;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic [MODE_W-1:0]    op_mode;
        logic [DIM_REG_W-1:0] a_rows;
        logic [DIM_REG_W-1:0] a_cols;
        logic [DIM_REG_W-1:0] b_cols;
    } cfg_t;

endpackage

// ===== rtl/mas_store.sv =====
// ----------------------------------------------------------------------------
// mas_store: element store with per-entry valid flags
// One write port, one read port with registered read data. An entry never
// written since reset reads as zero.
// ----------------------------------------------------------------------------
module mas_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic signed [W-1:0] rd_data
);

    logic signed [W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    vld_reg;
    logic signed [W-1:0] rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== rtl/mas_engine.sv =====
// ----------------------------------------------------------------------------
// mas_engine: load decode, run sequencer and arithmetic pipeline
// Loads write the stores; a start walks i, j, k over them, forms one product
// or sum per cycle unless stalled, accumulates with saturation, emits results.
// ----------------------------------------------------------------------------
module mas_engine #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16,
    parameter int AW         = 6,
    parameter int IW         = 3,
    parameter int DW         = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mas_pkg::cfg_t                        cfg,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mas_pkg::KIND_W-1:0]           kind,
    input  logic [mas_pkg::IDX_W-1:0]            row,
    input  logic [mas_pkg::IDX_W-1:0]            col,
    input  logic signed [mas_pkg::IN_W-1:0]      value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mas_pkg::IDX_W-1:0]            out_row,
    output logic [mas_pkg::IDX_W-1:0]            out_col,
    output logic signed [mas_pkg::OUT_W-1:0]     out_value,
    output logic                                 last,
    output logic                                 error,
    output logic                                 a_wr_en,
    output logic                                 b_wr_en,
    output logic [AW-1:0]                        wr_addr,
    output logic signed [ELEM_WIDTH-1:0]         wr_data,
    output logic                                 rd_en,
    output logic [AW-1:0]                        a_rd_addr,
    output logic [AW-1:0]                        b_rd_addr,
    input  logic signed [ELEM_WIDTH-1:0]         a_rd_data,
    input  logic signed [ELEM_WIDTH-1:0]         b_rd_data
);

    localparam int PW = 2 * ELEM_WIDTH + 9;
    localparam int SW = ((PW > mas_pkg::OUT_W) ? PW : mas_pkg::OUT_W) + 1;

    function automatic logic [DW-1:0] clamp_dim(input logic [mas_pkg::DIM_REG_W-1:0] r);
        logic [DW-1:0] d;
        d = (r > mas_pkg::DIM_REG_W'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(r);
        return d;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
        logic [AW-1:0] a;
        a = AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
        return a;
    endfunction

    logic [DW-1:0]   nr;
    logic [DW-1:0]   nc;
    logic [DW-1:0]   nb;
    logic [DW-1:0]   ocols;
    logic [DW-1:0]   klim;
    logic [DW-1:0]   lim_r;
    logic [DW-1:0]   lim_c;
    logic            mul;
    logic            knull;
    logic            advance;
    logic            accept;
    logic            is_load;
    logic            in_range;
    logic            load_err;
    logic            start_ok;
    logic            k_end;
    logic            j_end;
    logic            i_end;

    logic            run_reg;
    logic            run_next;
    logic [IW-1:0]   i_reg;
    logic [IW-1:0]   i_next;
    logic [IW-1:0]   j_reg;
    logic [IW-1:0]   j_next;
    logic [IW-1:0]   k_reg;
    logic [IW-1:0]   k_next;

    logic            s1_valid_reg;
    logic [IW-1:0]   s1_i_reg;
    logic [IW-1:0]   s1_j_reg;
    logic            s1_first_reg;
    logic            s1_lastk_reg;
    logic            s1_laste_reg;
    logic            s1_zero_reg;

    logic            s2_valid_reg;
    logic [IW-1:0]   s2_i_reg;
    logic [IW-1:0]   s2_j_reg;
    logic            s2_first_reg;
    logic            s2_lastk_reg;
    logic            s2_laste_reg;
    logic signed [PW-1:0] term_reg;
    logic signed [PW-1:0] term_next;

    logic signed [2*ELEM_WIDTH-1:0] prod;
    logic signed [ELEM_WIDTH:0]     a_x;
    logic signed [ELEM_WIDTH:0]     b_x;
    logic signed [ELEM_WIDTH:0]     ab;

    logic signed [mas_pkg::OUT_W-1:0] acc_reg;
    logic signed [mas_pkg::OUT_W-1:0] acc_base;
    logic signed [SW-1:0]             acc_sum;
    logic signed [mas_pkg::OUT_W-1:0] acc_sat;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [mas_pkg::IDX_W-1:0]        out_row_reg;
    logic [mas_pkg::IDX_W-1:0]        out_col_reg;
    logic signed [mas_pkg::OUT_W-1:0] out_value_reg;
    logic                             last_reg;
    logic                             error_reg;

    assign nr    = clamp_dim(cfg.a_rows);
    assign nc    = clamp_dim(cfg.a_cols);
    assign nb    = clamp_dim(cfg.b_cols);
    assign mul   = (cfg.op_mode == mas_pkg::MODE_MUL);
    assign ocols = mul ? nb : nc;
    assign knull = mul && (nc == '0);
    assign klim  = (mul && !knull) ? nc : DW'(1);

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = run_reg || s1_valid_reg || s2_valid_reg || !advance;
    assign accept   = in_valid && !in_stall;

    assign is_load  = (kind == mas_pkg::KIND_LOAD_A) || (kind == mas_pkg::KIND_LOAD_B);
    assign lim_r    = ((kind == mas_pkg::KIND_LOAD_B) && cfg.op_mode[1]) ? nc : nr;
    assign lim_c    = ((kind == mas_pkg::KIND_LOAD_B) && cfg.op_mode[1]) ? nb : nc;
    assign in_range = (mas_pkg::DIM_REG_W'(row) < mas_pkg::DIM_REG_W'(lim_r))
                   && (mas_pkg::DIM_REG_W'(col) < mas_pkg::DIM_REG_W'(lim_c));
    assign load_err = accept && is_load && !in_range;
    assign a_wr_en  = accept && (kind == mas_pkg::KIND_LOAD_A) && in_range;
    assign b_wr_en  = accept && (kind == mas_pkg::KIND_LOAD_B) && in_range;
    assign wr_addr  = addr_of(IW'(row), IW'(col));
    assign wr_data  = ELEM_WIDTH'(value);

    assign start_ok = accept && (kind == mas_pkg::KIND_START)
                   && (cfg.op_mode != mas_pkg::MODE_UNUSED)
                   && (nr != '0) && (ocols != '0);

    assign k_end = (DW'(k_reg) + DW'(1)) == klim;
    assign j_end = (DW'(j_reg) + DW'(1)) == ocols;
    assign i_end = (DW'(i_reg) + DW'(1)) == nr;

    assign rd_en     = run_reg && advance;
    assign a_rd_addr = mul ? addr_of(i_reg, k_reg) : addr_of(i_reg, j_reg);
    assign b_rd_addr = mul ? addr_of(k_reg, j_reg) : addr_of(i_reg, j_reg);

    always_comb
    begin
        run_next = run_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        if (start_ok)
        begin
            run_next = 1'b1;
            i_next   = '0;
            j_next   = '0;
            k_next   = '0;
        end
        else if (run_reg && advance)
        begin
            if (!k_end)
            begin
                k_next = k_reg + IW'(1);
            end
            else
            begin
                k_next = '0;
                if (!j_end)
                begin
                    j_next = j_reg + IW'(1);
                end
                else
                begin
                    j_next = '0;
                    if (!i_end)
                    begin
                        i_next = i_reg + IW'(1);
                    end
                    else
                    begin
                        run_next = 1'b0;
                    end
                end
            end
        end
    end

    assign prod = a_rd_data * b_rd_data;
    assign a_x  = (ELEM_WIDTH + 1)'(a_rd_data);
    assign b_x  = (ELEM_WIDTH + 1)'(b_rd_data);
    assign ab   = (cfg.op_mode == mas_pkg::MODE_ADD) ? (a_x + b_x) : (a_x - b_x);

    always_comb
    begin
        if (s1_zero_reg)
        begin
            term_next = '0;
        end
        else if (mul)
        begin
            term_next = PW'(prod);
        end
        else
        begin
            term_next = PW'(ab) <<< 8;
        end
    end

    assign acc_base = s2_first_reg ? '0 : acc_reg;
    assign acc_sum  = SW'(acc_base) + SW'(term_reg);

    always_comb
    begin
        if (acc_sum > SW'(mas_pkg::OUT_MAX))
        begin
            acc_sat = mas_pkg::OUT_MAX;
        end
        else if (acc_sum < SW'(mas_pkg::OUT_MIN))
        begin
            acc_sat = mas_pkg::OUT_MIN;
        end
        else
        begin
            acc_sat = mas_pkg::OUT_W'(acc_sum);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = (s2_valid_reg && s2_lastk_reg) || load_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                s1_valid_reg <= run_reg;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_i_reg     <= i_reg;
            s1_j_reg     <= j_reg;
            s1_first_reg <= (k_reg == '0);
            s1_lastk_reg <= k_end;
            s1_laste_reg <= k_end && j_end && i_end;
            s1_zero_reg  <= knull;

            s2_i_reg     <= s1_i_reg;
            s2_j_reg     <= s1_j_reg;
            s2_first_reg <= s1_first_reg;
            s2_lastk_reg <= s1_lastk_reg;
            s2_laste_reg <= s1_laste_reg;
            term_reg     <= term_next;

            if (s2_valid_reg)
            begin
                acc_reg <= acc_sat;
            end

            if (load_err)
            begin
                out_row_reg   <= row;
                out_col_reg   <= col;
                out_value_reg <= '0;
                last_reg      <= 1'b1;
                error_reg     <= 1'b1;
            end
            else if (s2_valid_reg && s2_lastk_reg)
            begin
                out_row_reg   <= mas_pkg::IDX_W'(s2_i_reg);
                out_col_reg   <= mas_pkg::IDX_W'(s2_j_reg);
                out_value_reg <= acc_sat;
                last_reg      <= s2_laste_reg;
                error_reg     <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;
    assign error     = error_reg;

`ifndef SYNTH
    a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (a_wr_en || b_wr_en) |-> (!run_reg && !s1_valid_reg && !s2_valid_reg))
        else $error("store write while a run is in flight");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(run_reg) |-> (s1_valid_reg && s1_laste_reg))
        else $error("run ended without issuing the final element");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (DW'(k_reg) < klim))
        else $error("inner index beyond its limit");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && error_reg) |-> (last_reg && (out_value_reg == '0)))
        else $error("error result malformed");
`endif

endmodule

// ===== rtl/matrix_add_sub_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_add_sub_multiply_unit: dense matrix add, subtract and multiply
// Loads elements of A and B into two stores, then on a start emits A+B, A-B
// or A*B in row-major order with the final element flagged.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | kind, row, col, value
//   out     | out_valid / out_stall| out_row, out_col, out_value, last, error
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Loads may follow back to back while the output is not stalled.
// A rejected load puts its error result in the output register on the next cycle.
// A start makes rows * cols * k store reads (k = a_cols in multiply, else 1;
// 1 if a_cols is 0), one per cycle unless stalled; in_stall is high until
// the last element has reached the output register.
// Stores read as zero after reset through per-entry valid flags.
// With out_valid high, out_stall freezes the whole pipeline, reads included.
// ----------------------------------------------------------------------------
module matrix_add_sub_multiply_unit #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [mas_pkg::KIND_W-1:0]           kind,
    input  logic [mas_pkg::IDX_W-1:0]            row,
    input  logic [mas_pkg::IDX_W-1:0]            col,
    input  logic signed [mas_pkg::IN_W-1:0]      value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [mas_pkg::IDX_W-1:0]            out_row,
    output logic [mas_pkg::IDX_W-1:0]            out_col,
    output logic signed [mas_pkg::OUT_W-1:0]     out_value,
    output logic                                 last,
    output logic                                 error,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mas_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mas_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);

    mas_pkg::cfg_t cfg_reg;

    logic                        a_wr_en;
    logic                        b_wr_en;
    logic [AW-1:0]               wr_addr;
    logic signed [ELEM_WIDTH-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               a_rd_addr;
    logic [AW-1:0]               b_rd_addr;
    logic signed [ELEM_WIDTH-1:0] a_rd_data;
    logic signed [ELEM_WIDTH-1:0] b_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_mode <= mas_pkg::MODE_ADD;
            cfg_reg.a_rows  <= mas_pkg::DIM_RESET;
            cfg_reg.a_cols  <= mas_pkg::DIM_RESET;
            cfg_reg.b_cols  <= mas_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mas_pkg::REG_OP_MODE: cfg_reg.op_mode <= cfg_data[mas_pkg::MODE_W-1:0];
                mas_pkg::REG_A_ROWS:  cfg_reg.a_rows  <= cfg_data;
                mas_pkg::REG_A_COLS:  cfg_reg.a_cols  <= cfg_data;
                mas_pkg::REG_B_COLS:  cfg_reg.b_cols  <= cfg_data;
                default:              cfg_reg         <= cfg_reg;
            endcase
        end
    end

    mas_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (ELEM_WIDTH)
    ) u_a_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (a_rd_addr),
        .rd_data (a_rd_data)
    );

    mas_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (ELEM_WIDTH)
    ) u_b_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd_data)
    );

    mas_engine #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH),
        .AW         (AW),
        .IW         (IW),
        .DW         (DW)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .last      (last),
        .error     (error),
        .a_wr_en   (a_wr_en),
        .b_wr_en   (b_wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .a_rd_addr (a_rd_addr),
        .b_rd_addr (b_rd_addr),
        .a_rd_data (a_rd_data),
        .b_rd_data (b_rd_data)
    );

endmodule
